// ===== rtl/sle_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sle_pkg
// Shared constants and types of the sequential list engine.
// ----------------------------------------------------------------------------
package sle_pkg;

	localparam int CAPACITY = 64;
	localparam int AW = $clog2(CAPACITY);
	localparam int LW = $clog2(CAPACITY + 1);
	localparam int PW = 7;
	localparam int CW = ((LW > PW) ? LW : PW) + 1;

	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_DELETE = 2'd1,
		CMD_GET    = 2'd2,
		CMD_LOCATE = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_DRAIN,
		S_PUT,
		S_FINISH
	} state_t;

endpackage
`default_nettype wire

// ===== rtl/sle_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sle_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module sle_ram #(
	parameter int DW = 8,
	parameter int AW = 6
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [DW-1:0] wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output logic      [DW-1:0] rdata
);

	logic [DW-1:0] mem [2**AW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

// ===== rtl/sequential_list_engine.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sequential_list_engine
// Ordered list of bytes held in one RAM, with insert, delete, get and locate.
//
// Commands arrive on the input channel (in_valid/in_ready); each transfer
// yields exactly one result on the output channel (out_valid/out_ready).
// One command is worked on at a time. The walk over the stored elements
// runs through the single RAM read port, one element per cycle, with the
// shift write-back pipelined behind the read. An insert that appends
// skips the walk and writes the value directly; refused commands (bad
// position, full list, empty locate) skip it and go straight to finish.
// The result sits in an output register, so the next command is taken
// while a result still waits; a stalled receiver only holds the finish of
// the following command. Reset (arst_n low) empties the list and drops any
// pending result; the RAM contents are not cleared, as entries at or above
// the length are never read.
// ----------------------------------------------------------------------------
module sequential_list_engine (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic [1:0]           command,
	input  wire logic [sle_pkg::PW-1:0] position,
	input  wire logic [7:0]           value,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic                      ok,
	output logic [7:0]                element,
	output logic [sle_pkg::PW-1:0]    found_at,
	output logic [sle_pkg::PW-1:0]    count,
	output logic                      is_empty
);

	import sle_pkg::*;

	state_t             state_q, state_d;
	cmd_t               cmd_in, cmd_q;
	logic [LW-1:0]      len_q, len_next;
	logic [AW-1:0]      idx_q, end_q, pos_m1_q, rd_addr_s1;
	logic [7:0]         val_q;
	logic               rd_v_s1;
	logic               res_ok_q;
	logic [7:0]         res_elem_q;
	logic [PW-1:0]      res_found_q;
	logic               out_valid_q, ok_q, empty_q;
	logic [7:0]         elem_q;
	logic [PW-1:0]      found_q, count_q;

	logic               fire_in, issue, finish_go, hit;
	logic [CW-1:0]      pos_x, len_x;
	logic               ins_ok, rd_ok, loc_go, append;
	logic [AW-1:0]      pos_m1_in, len_m1;
	logic [AW:0]        hit_pos;
	logic               we;
	logic [AW-1:0]      waddr;
	logic [7:0]         wdata, rdata;

	assign cmd_in    = cmd_t'(command);
	assign in_ready  = (state_q == S_IDLE);
	assign fire_in   = in_valid && in_ready;
	assign pos_x     = CW'(position);
	assign len_x     = CW'(len_q);
	assign pos_m1_in = AW'(position - PW'(1));
	assign len_m1    = AW'(len_q - LW'(1));
	assign ins_ok    = (pos_x != '0) && (pos_x <= len_x + CW'(1))
			&& (len_x < CW'(CAPACITY));
	assign rd_ok     = (pos_x != '0) && (pos_x <= len_x);
	assign loc_go    = (len_q != '0);
	assign append    = (pos_x == len_x + CW'(1));
	assign hit       = rd_v_s1 && (cmd_q == CMD_LOCATE) && !res_ok_q && (rdata == val_q);
	assign hit_pos   = {1'b0, rd_addr_s1} + (AW+1)'(1);
	assign finish_go = (state_q == S_FINISH) && (!out_valid_q || out_ready);

	always_comb begin
		state_d = state_q;
		issue   = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (fire_in) begin
					state_d = S_FINISH;
					unique case (cmd_in)
						CMD_INSERT: begin
							if (ins_ok) begin
								state_d = append ? S_PUT : S_SCAN;
							end
						end
						CMD_DELETE, CMD_GET: begin
							if (rd_ok) begin
								state_d = S_SCAN;
							end
						end
						CMD_LOCATE: begin
							if (loc_go) begin
								state_d = S_SCAN;
							end
						end
						default: state_d = S_FINISH;
					endcase
				end
			end
			S_SCAN: begin
				if (hit) begin
					state_d = S_DRAIN;
				end else begin
					issue = 1'b1;
					if (idx_q == end_q) begin
						state_d = S_DRAIN;
					end
				end
			end
			S_DRAIN: begin
				if (!rd_v_s1) begin
					state_d = (cmd_q == CMD_INSERT) ? S_PUT : S_FINISH;
				end
			end
			S_PUT: state_d = S_FINISH;
			S_FINISH: begin
				if (finish_go) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// ram write port: shift write-back has priority, final insert write last
	always_comb begin
		we    = 1'b0;
		waddr = rd_addr_s1;
		wdata = rdata;
		if (rd_v_s1 && (cmd_q == CMD_INSERT)) begin
			we    = 1'b1;
			waddr = rd_addr_s1 + AW'(1);
		end else if (rd_v_s1 && (cmd_q == CMD_DELETE) && (rd_addr_s1 != pos_m1_q)) begin
			we    = 1'b1;
			waddr = rd_addr_s1 - AW'(1);
		end else if (state_q == S_PUT) begin
			we    = 1'b1;
			waddr = pos_m1_q;
			wdata = val_q;
		end
	end

	sle_ram #(
		.DW (8),
		.AW (AW)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (issue),
		.raddr (idx_q),
		.rdata (rdata)
	);

	always_ff @(posedge clk) begin
		rd_addr_s1 <= idx_q;
		if (fire_in) begin
			cmd_q       <= cmd_in;
			val_q       <= value;
			pos_m1_q    <= pos_m1_in;
			res_elem_q  <= '0;
			res_found_q <= '0;
			unique case (cmd_in)
				CMD_INSERT: begin
					res_ok_q <= ins_ok;
					idx_q    <= len_m1;
					end_q    <= pos_m1_in;
				end
				CMD_DELETE: begin
					res_ok_q <= rd_ok;
					idx_q    <= pos_m1_in;
					end_q    <= len_m1;
				end
				CMD_GET: begin
					res_ok_q <= rd_ok;
					idx_q    <= pos_m1_in;
					end_q    <= pos_m1_in;
				end
				CMD_LOCATE: begin
					res_ok_q <= 1'b0;
					idx_q    <= '0;
					end_q    <= len_m1;
				end
				default: res_ok_q <= 1'b0;
			endcase
		end else begin
			if (issue) begin
				idx_q <= (cmd_q == CMD_INSERT) ? idx_q - AW'(1) : idx_q + AW'(1);
			end
			if (rd_v_s1 && (cmd_q inside {CMD_DELETE, CMD_GET})
					&& (rd_addr_s1 == pos_m1_q)) begin
				res_elem_q <= rdata;
			end
			if (hit) begin
				res_ok_q    <= 1'b1;
				res_found_q <= PW'(hit_pos);
			end
		end
	end

	always_comb begin
		len_next = len_q;
		if (res_ok_q && (cmd_q == CMD_INSERT)) begin
			len_next = len_q + LW'(1);
		end else if (res_ok_q && (cmd_q == CMD_DELETE)) begin
			len_next = len_q - LW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_v_s1     <= 1'b0;
			len_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			rd_v_s1 <= issue;
			if (finish_go) begin
				len_q       <= len_next;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (finish_go) begin
			ok_q    <= res_ok_q;
			elem_q  <= res_elem_q;
			found_q <= res_found_q;
			count_q <= PW'(len_next);
			empty_q <= (len_next == '0);
		end
	end

	assign out_valid = out_valid_q;
	assign ok        = ok_q;
	assign element   = elem_q;
	assign found_at  = found_q;
	assign count     = count_q;
	assign is_empty  = empty_q;

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LW'(CAPACITY))
		else $error("list length above capacity");

	a_idle_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !we && !rd_v_s1)
		else $error("ram access while idle");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		finish_go && res_ok_q && (cmd_q == CMD_INSERT) |=> len_q == $past(len_q) + LW'(1))
		else $error("insert did not grow the list");

	a_scan_needs_items: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> len_q != '0)
		else $error("scan over an empty list");

endmodule
`default_nettype wire
